/* design/eiwd_pkg.sv */
// Shared types and constants for the echo interval window detector.
`default_nettype none

package eiwd_pkg;

  localparam int unsigned EIWD_WINDOW = 10;

  localparam int unsigned TIME_W  = 16;
  localparam int unsigned LIMIT_W = 20;
  localparam int unsigned COUNT_W = 8;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DAT_W = 20;

  // Operating modes held in the mode register.
  localparam logic [1:0] MODE_OFF  = 2'd0;
  localparam logic [1:0] MODE_CUP  = 2'd1;
  localparam logic [1:0] MODE_EDGE = 2'd2;

  // Input word kinds.
  localparam logic KIND_START   = 1'b0;
  localparam logic KIND_CAPTURE = 1'b1;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MODE       = 3'd0,
    REG_TABLE_MAX  = 3'd1,
    REG_CUP_MIN    = 3'd2,
    REG_FOUND_SUM  = 3'd3,
    REG_EDGE_LIMIT = 3'd4
  } cfg_reg_e;

  // Reset values of the configuration registers.
  localparam logic [1:0]         RST_MODE       = MODE_OFF;
  localparam logic [TIME_W-1:0]  RST_TABLE_MAX  = 16'd3800;
  localparam logic [TIME_W-1:0]  RST_CUP_MIN    = 16'd1500;
  localparam logic [LIMIT_W-1:0] RST_FOUND_SUM  = 20'd25000;
  localparam logic [COUNT_W-1:0] RST_EDGE_LIMIT = 8'd2;

  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  // Window control from the top level to the cell chain.
  typedef struct packed {
    logic clr;   // empty the window, sum and fill count
    logic push;  // shift a new interval in
  } win_ctrl_t;

endpackage

`default_nettype wire

/* design/eiwd_cell.sv */
// One window cell: holds an interval and passes it on to the next cell on a push.
`default_nettype none

module eiwd_cell
  import eiwd_pkg::*;
(
  input  wire logic              clk_i,
  input  wire win_ctrl_t         ctrl_i,
  input  wire logic [TIME_W-1:0] data_i,
  output logic      [TIME_W-1:0] data_o
);

  logic [TIME_W-1:0] val_q, val_d;

  always_comb begin
    val_d = val_q;
    if (ctrl_i.clr) begin
      val_d = '0;
    end else if (ctrl_i.push) begin
      val_d = data_i;
    end
  end

  // payload only; every measurement starts with a clear
  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

  assign data_o = val_q;

endmodule

`default_nettype wire

/* design/eiwd_window.sv */
// Interval window: chain of cells, running sum and fill tracking.
`default_nettype none

module eiwd_window
  import eiwd_pkg::*;
#(
  parameter int unsigned WINDOW = EIWD_WINDOW,
  parameter int unsigned SUM_W  = TIME_W + $clog2(WINDOW)
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire win_ctrl_t         ctrl_i,
  input  wire logic [TIME_W-1:0] data_i,
  output logic      [SUM_W-1:0]  sum_next_o,    // sum including data_i
  output logic                   filled_next_o  // window full after this push
);

  localparam int unsigned POS_W = $clog2(WINDOW);
  localparam logic [POS_W-1:0] POS_LAST = POS_W'(WINDOW - 1);

  logic [TIME_W-1:0] tap [WINDOW];

  logic [SUM_W-1:0] sum_q, sum_d;
  logic [POS_W-1:0] pos_q, pos_d;
  logic             filled_q, filled_d;

  for (genvar k = 0; k < WINDOW; k++) begin : g_cell
    if (k == 0) begin : g_head
      eiwd_cell u_cell (
        .clk_i  (clk_i),
        .ctrl_i (ctrl_i),
        .data_i (data_i),
        .data_o (tap[k])
      );
    end else begin : g_body
      eiwd_cell u_cell (
        .clk_i  (clk_i),
        .ctrl_i (ctrl_i),
        .data_i (tap[k-1]),
        .data_o (tap[k])
      );
    end
  end

  // oldest entry leaves the tail as the new one enters the head
  assign sum_next_o = sum_q - SUM_W'(tap[WINDOW-1]) + SUM_W'(data_i);
  assign filled_next_o = filled_q || (pos_q == POS_LAST);

  always_comb begin
    sum_d    = sum_q;
    pos_d    = pos_q;
    filled_d = filled_q;
    if (ctrl_i.clr) begin
      sum_d    = '0;
      pos_d    = '0;
      filled_d = 1'b0;
    end else if (ctrl_i.push) begin
      sum_d    = sum_next_o;
      pos_d    = (pos_q == POS_LAST) ? '0 : pos_q + POS_W'(1);
      filled_d = filled_next_o;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q    <= '0;
      pos_q    <= '0;
      filled_q <= 1'b0;
    end else begin
      sum_q    <= sum_d;
      pos_q    <= pos_d;
      filled_q <= filled_d;
    end
  end

endmodule

`default_nettype wire

/* design/echo_interval_window_detector_unit.sv */
// Top level of the echo interval window detector.
//
//   channel | direction | handshake               | payload
//   --------+-----------+-------------------------+----------------------------------
//   input   | in        | in_valid_i/in_ready_o   | kind_i, capture_time_i
//   result  | out       | out_valid_o/out_ready_i | cup_flag_o, edge_found_o, interval_o
//   config  | in        | cfg_we_i                | cfg_idx_i, cfg_wdata_i
//
// One word in, one word out. A word is processed in the cycle it is accepted
// and its result sits in the output register on the next cycle, so one word
// per cycle is sustained while the output is not stalled; the limit is the
// subtract, window sum update and compares feeding the output register.
// in_ready_o drops only while a finished result waits in the output register
// with out_ready_i low.
// Reset is asynchronous, active low; it clears control state and loads the
// register defaults. Window cells need no reset since the first capture
// after reset or a start clears them.
`default_nettype none

module echo_interval_window_detector_unit
  import eiwd_pkg::*;
#(
  parameter int unsigned WINDOW = EIWD_WINDOW
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  // configuration write port
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [CFG_DAT_W-1:0] cfg_wdata_i,
  // input words
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire logic                 kind_i,
  input  wire logic [TIME_W-1:0]    capture_time_i,
  // result words
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output logic                      cup_flag_o,
  output logic                      edge_found_o,
  output logic      [TIME_W-1:0]    interval_o
);

  localparam int unsigned SUM_W = TIME_W + $clog2(WINDOW);
  localparam int unsigned CMP_W = (SUM_W > LIMIT_W) ? SUM_W : LIMIT_W;

  // configuration registers
  logic [1:0]         mode_q;
  logic [TIME_W-1:0]  table_max_q;
  logic [TIME_W-1:0]  cup_min_q;
  logic [LIMIT_W-1:0] found_sum_q;
  logic [COUNT_W-1:0] edge_limit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q       <= RST_MODE;
      table_max_q  <= RST_TABLE_MAX;
      cup_min_q    <= RST_CUP_MIN;
      found_sum_q  <= RST_FOUND_SUM;
      edge_limit_q <= RST_EDGE_LIMIT;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_MODE:       mode_q       <= cfg_wdata_i[1:0];
        REG_TABLE_MAX:  table_max_q  <= cfg_wdata_i[TIME_W-1:0];
        REG_CUP_MIN:    cup_min_q    <= cfg_wdata_i[TIME_W-1:0];
        REG_FOUND_SUM:  found_sum_q  <= cfg_wdata_i[LIMIT_W-1:0];
        REG_EDGE_LIMIT: edge_limit_q <= cfg_wdata_i[COUNT_W-1:0];
        default: ;  // unmapped index, dropped
      endcase
    end
  end

  // measurement state
  logic               first_q, first_d;
  logic               halted_q, halted_d;
  logic [TIME_W-1:0]  prev_q, prev_d;
  logic [COUNT_W-1:0] long_cnt_q, long_cnt_d;

  // output register
  logic               out_valid_q, out_valid_d;
  logic               cup_q, cup_d;
  logic               edge_q, edge_d;
  logic [TIME_W-1:0]  interval_q, interval_d;

  logic              accept;
  logic [TIME_W-1:0] diff;
  logic              in_band;
  win_ctrl_t         win_ctrl;
  logic [SUM_W-1:0]  sum_next;
  logic              filled_next;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  assign diff    = capture_time_i - prev_q;  // wraps at 16 bits
  assign in_band = (diff < table_max_q) && (diff > cup_min_q);

  eiwd_window #(
    .WINDOW (WINDOW),
    .SUM_W  (SUM_W)
  ) u_window (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ctrl_i        (win_ctrl),
    .data_i        (diff),
    .sum_next_o    (sum_next),
    .filled_next_o (filled_next)
  );

  always_comb begin
    first_d     = first_q;
    halted_d    = halted_q;
    prev_d      = prev_q;
    long_cnt_d  = long_cnt_q;
    win_ctrl    = '0;
    out_valid_d = out_valid_q && !out_ready_i;
    cup_d       = cup_q;
    edge_d      = edge_q;
    interval_d  = interval_q;

    if (accept) begin
      out_valid_d = 1'b1;
      cup_d       = 1'b0;
      edge_d      = 1'b0;
      interval_d  = '0;
      if (kind_i == KIND_START) begin
        // rearm: next capture records time and clears the window
        first_d  = 1'b1;
        halted_d = 1'b0;
      end else if (!halted_q) begin
        if (first_q) begin
          win_ctrl.clr = 1'b1;
          long_cnt_d   = '0;
          prev_d       = capture_time_i;
          first_d      = 1'b0;
        end else begin
          prev_d     = capture_time_i;
          interval_d = diff;
          if (mode_q == MODE_CUP && in_band) begin
            win_ctrl.push = 1'b1;
            if (filled_next && (CMP_W'(sum_next) < CMP_W'(found_sum_q))) begin
              cup_d    = 1'b1;
              halted_d = 1'b1;
            end
          end else if (mode_q == MODE_EDGE) begin
            // long interval counts up, a cup-length one resets the run
            if (diff > table_max_q) begin
              if (long_cnt_q != COUNT_MAX) begin
                long_cnt_d = long_cnt_q + COUNT_W'(1);
              end
            end else if (diff > cup_min_q) begin
              long_cnt_d = '0;
            end
            if (long_cnt_d >= edge_limit_q) begin
              edge_d   = 1'b1;
              halted_d = 1'b1;
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_q     <= 1'b1;
      halted_q    <= 1'b0;
      prev_q      <= '0;
      long_cnt_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      first_q     <= first_d;
      halted_q    <= halted_d;
      prev_q      <= prev_d;
      long_cnt_q  <= long_cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cup_q      <= cup_d;
    edge_q     <= edge_d;
    interval_q <= interval_d;
  end

  assign out_valid_o  = out_valid_q;
  assign cup_flag_o   = cup_q;
  assign edge_found_o = edge_q;
  assign interval_o   = interval_q;

endmodule

`default_nettype wire

/* design/eiwd_checker.sv */
// Port-level checks for the echo interval window detector, bound to the top level.
`default_nettype none

module eiwd_checker
  import eiwd_pkg::*;
(
  input wire logic                 clk_i,
  input wire logic                 rst_ni,
  input wire logic                 in_valid_i,
  input wire logic                 in_ready_o,
  input wire logic                 kind_i,
  input wire logic                 out_valid_o,
  input wire logic                 out_ready_i,
  input wire logic                 cup_flag_o,
  input wire logic                 edge_found_o,
  input wire logic [TIME_W-1:0]    interval_o
);

  // cup and edge detection sit in different modes, so one word never flags both
  a_one_detect : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(cup_flag_o && edge_found_o))
    else $error("cup and edge flagged in one word");

  // every accepted word yields a result on the next cycle
  a_result_follows : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> out_valid_o)
    else $error("accepted word produced no result");

  // a start word gives an all-zero result
  a_start_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && kind_i == KIND_START) |=>
      (!cup_flag_o && !edge_found_o && interval_o == '0))
    else $error("start word result not zero");

  // a stalled result holds
  a_out_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=>
      (out_valid_o && $stable(interval_o) && $stable(cup_flag_o)
       && $stable(edge_found_o)))
    else $error("stalled result changed");

  // input side stalls only behind a held result
  a_ready_stall : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (out_valid_o && !out_ready_i))
    else $error("input stalled without a held result");

endmodule

bind echo_interval_window_detector_unit eiwd_checker u_eiwd_checker (.*);

`default_nettype wire
